@@ src/clf_pkg.sv @@
`timescale 1ns / 1ps
package clf_pkg;
  localparam int MaxItems = 64;
  localparam int IdxW = $clog2(MaxItems);
  localparam int CntW = IdxW + 1;
  localparam int ValW = 32;
  localparam int LenW = 7;

  localparam logic [1:0] RegTargetLen = 2'd0;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_RDI, ST_RDJ, ST_WAITJ, ST_CMP, ST_WRI,
    ST_WALK_RD, ST_WALK_WR, ST_OUT_RD, ST_OUT_WAIT, ST_OUT_HOLD, ST_NF
  } clf_state_e;

  typedef struct packed {
    logic load_wr;
    logic init;
    logic rd_i;
    logic cmp;
    logic wr_i;
    logic next_j;
    logic walk_rd;
    logic walk_wr;
    logic out_cap;
    logic nf;
  } clf_cmd_t;

  typedef struct packed {
    logic hit;
    logic j_done;
    logic i_done;
    logic rot_done;
    logic walk_done;
    logic out_done;
    logic out_busy;
  } clf_sts_t;
endpackage

@@ src/clf_ram.sv @@
`timescale 1ns / 1ps
module clf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ src/clf_ctrl.sv @@
`timescale 1ns / 1ps
module clf_ctrl import clf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  logic     in_last_i,
  input  clf_sts_t sts_i,
  output clf_cmd_t cmd_o,
  output logic     in_ready_o
);
  clf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load_wr = in_fire_i;
        if (in_fire_i && in_last_i) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d = ST_RDI;
      end
      ST_RDI: begin
        // i loop start; nothing to do for a single element
        if (sts_i.i_done) begin
          cmd_o.next_j = 1'b1;
          state_d = sts_i.rot_done ? ST_NF : ST_INIT;
        end else begin
          cmd_o.rd_i = 1'b1;
          state_d = ST_RDJ;
        end
      end
      ST_RDJ: state_d = ST_WAITJ;
      ST_WAITJ: state_d = ST_CMP;
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.hit) state_d = ST_WALK_RD;
        else if (sts_i.j_done) state_d = ST_WRI;
        else state_d = ST_RDJ;
      end
      ST_WRI: begin
        cmd_o.wr_i = 1'b1;
        state_d = ST_RDI;
      end
      ST_WALK_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        cmd_o.walk_wr = 1'b1;
        state_d = sts_i.walk_done ? ST_OUT_RD : ST_WALK_RD;
      end
      ST_OUT_RD: state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_cap = 1'b1;
          state_d = sts_i.out_done ? ST_OUT_HOLD : ST_OUT_RD;
        end
      end
      ST_OUT_HOLD: if (!sts_i.out_busy) state_d = ST_LOAD;
      ST_NF: begin
        if (!sts_i.out_busy) begin
          cmd_o.nf = 1'b1;
          state_d = ST_OUT_HOLD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end
endmodule

@@ src/clf_dp.sv @@
`timescale 1ns / 1ps
module clf_dp import clf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  clf_cmd_t                cmd_i,
  input  logic signed [ValW-1:0]  in_value_i,
  input  logic [LenW-1:0]         target_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [ValW-1:0]         out_value_o,
  output logic                    out_found_o,
  output logic [LenW-1:0]         out_count_o,
  output logic                    out_last_o,
  output clf_sts_t                sts_o
);
  logic [CntW-1:0] cnt_q, n_q, i_q, j_q, t_q;
  logic [IdxW-1:0] rot_q, widx_q;
  logic [LenW-1:0] k_q, m_q, len_i_q;
  logic [IdxW-1:0] pred_i_q;
  logic [ValW-1:0] vi_q;
  logic            rd_i_q;
  logic            ovalid_q, ofound_q, olast_q;
  logic [ValW-1:0] oval_q;
  logic [LenW-1:0] ocnt_q;

  // value RAM
  logic            v_we;
  logic [IdxW-1:0] v_wa, v_ra;
  logic [ValW-1:0] v_rd;
  // length/pred RAM, {len, pred}
  logic            l_we;
  logic [IdxW-1:0] l_wa, l_ra;
  logic [LenW+IdxW-1:0] l_wd, l_rd;
  // run buffer, one value per run position
  logic            c_we;
  logic [IdxW-1:0] c_wa, c_ra;
  logic [ValW-1:0] c_rd;

  // wrap (rot + x) mod n, x < n
  function automatic logic [IdxW-1:0] wrap(input logic [IdxW-1:0] r,
                                           input logic [CntW-1:0] x,
                                           input logic [CntW-1:0] n);
    logic [CntW:0] s;
    s = {1'b0, 1'b0, r} + {1'b0, x};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[IdxW-1:0];
  endfunction

  assign v_we = cmd_i.load_wr && (cnt_q < CntW'(MaxItems));
  assign v_wa = cnt_q[IdxW-1:0];
  always_comb begin
    v_ra = wrap(rot_q, j_q, n_q);
    if (cmd_i.rd_i) v_ra = wrap(rot_q, i_q, n_q);
    if (cmd_i.walk_rd) v_ra = wrap(rot_q, {1'b0, widx_q}, n_q);
  end
  assign l_ra = cmd_i.walk_rd ? widx_q : j_q[IdxW-1:0];
  assign l_we = cmd_i.wr_i;
  assign l_wa = i_q[IdxW-1:0];
  assign l_wd = {len_i_q, pred_i_q};

  // trace back fills the buffer from the top, output reads it from 0 up
  assign c_we = cmd_i.walk_wr;
  assign c_wa = k_q[IdxW-1:0] - IdxW'(1);
  assign c_ra = m_q[IdxW-1:0];

  clf_ram #(.Width(ValW), .Depth(MaxItems)) u_val (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(in_value_i),
    .raddr_i(v_ra), .rdata_o(v_rd));
  clf_ram #(.Width(LenW+IdxW), .Depth(MaxItems)) u_len (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd),
    .raddr_i(l_ra), .rdata_o(l_rd));
  clf_ram #(.Width(ValW), .Depth(MaxItems)) u_run (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(v_rd),
    .raddr_i(c_ra), .rdata_o(c_rd));

  // first row (index 0) always has length 1: reading j=0 gives 1
  logic [LenW-1:0] len_j, cand;
  logic            gt;
  assign len_j = (j_q == '0) ? LenW'(1) : l_rd[LenW+IdxW-1:IdxW];
  assign cand  = len_j + LenW'(1);
  assign gt    = $signed(vi_q) > $signed(v_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; n_q <= '0; i_q <= '0; j_q <= '0; t_q <= '0;
      rot_q <= '0; widx_q <= '0; k_q <= '0; m_q <= '0;
      len_i_q <= '0; pred_i_q <= '0; vi_q <= '0; rd_i_q <= 1'b0;
      ovalid_q <= 1'b0; ofound_q <= 1'b0; olast_q <= 1'b0;
      oval_q <= '0; ocnt_q <= '0;
    end else begin
      rd_i_q <= cmd_i.rd_i;
      if (rd_i_q) vi_q <= v_rd;

      // start of search: latch n, drop the count
      if (cmd_i.init && t_q == '0) cnt_q <= '0;
      else if (v_we) cnt_q <= cnt_q + 1'b1;

      if (cmd_i.init) begin
        if (t_q == '0) begin
          // first rotation is 1, or 0 for a single element
          n_q   <= cnt_q;
          rot_q <= (cnt_q == CntW'(1)) ? '0 : IdxW'(1);
        end else begin
          rot_q <= ((t_q + 1'b1) == n_q) ? '0 : rot_q + 1'b1;
        end
      end

      if (cmd_i.init) t_q <= t_q + 1'b1;
      else if ((cmd_i.next_j && t_q == n_q) || cmd_i.nf ||
               (cmd_i.out_cap && sts_o.out_done)) t_q <= '0;

      if (cmd_i.init) i_q <= CntW'(1);
      else if (cmd_i.wr_i) i_q <= i_q + 1'b1;

      if (cmd_i.rd_i) j_q <= '0;
      else if (cmd_i.cmp) j_q <= j_q + 1'b1;

      if (cmd_i.rd_i) begin
        len_i_q <= LenW'(1);
        pred_i_q <= '0;
      end else if (cmd_i.cmp && gt && cand > len_i_q) begin
        len_i_q <= cand;
        pred_i_q <= j_q[IdxW-1:0];
      end

      // trace back: the end row is not in the RAM yet, take its pred directly
      if (sts_o.hit) begin
        k_q <= target_i;
        widx_q <= i_q[IdxW-1:0];
      end else if (cmd_i.walk_wr) begin
        k_q <= k_q - 1'b1;
        widx_q <= (k_q == target_i) ? pred_i_q : l_rd[IdxW-1:0];
      end

      if (sts_o.hit) m_q <= '0;
      else if (cmd_i.out_cap) m_q <= m_q + 1'b1;

      if (cmd_i.out_cap) begin
        ovalid_q <= 1'b1;
        oval_q <= c_rd;
        ofound_q <= 1'b1;
        ocnt_q <= target_i;
        olast_q <= sts_o.out_done;
      end else if (cmd_i.nf) begin
        ovalid_q <= 1'b1;
        oval_q <= '0; ofound_q <= 1'b0; ocnt_q <= '0; olast_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign sts_o.hit       = cmd_i.cmp && gt && (cand == target_i);
  assign sts_o.j_done    = (j_q + 1'b1) == i_q;
  assign sts_o.i_done    = i_q >= n_q;
  assign sts_o.rot_done  = t_q >= n_q;
  assign sts_o.walk_done = k_q == LenW'(1);
  assign sts_o.out_done  = (m_q + LenW'(1)) == target_i;
  assign sts_o.out_busy  = ovalid_q && !out_ready_i;

  assign out_valid_o = ovalid_q;
  assign out_value_o = oval_q;
  assign out_found_o = ofound_q;
  assign out_count_o = ocnt_q;
  assign out_last_o  = olast_q;

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_value_o)) else $error("result changed");
  a_j_lt_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmp |-> j_q < i_q) else $error("j passed i");
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxItems)) else $error("count overflow");
`endif
endmodule

@@ src/circular_lis_finder.sv @@
`timescale 1ns / 1ps
// Circular LIS finder. Load signed 32-bit words one per cycle; the word
// with tlast starts a search over rotations 1..n-1 then 0, each running the
// quadratic strictly-increasing LIS program, stopping at the first run length
// equal to target_len. The found run streams out ascending, tagged found, with
// tlast on its final word; otherwise one word with found clear. The search
// works through the (i, j) pairs of each row and rotation in turn, paced by
// the single read port of the value and length memories. Output first
// traces the run back into a buffer, a read and a write per element, then
// streams it out word by word, waiting while tready is low. No words are
// accepted during the search and output.
module circular_lis_finder import clf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // item_value[31:0]
  input  logic        s_axis_tlast_i,  // item_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // seq_value[31:0], result_count[38:32], 0
  output logic        m_axis_tuser_o,  // found
  output logic        m_axis_tlast_o,  // run_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [LenW-1:0] target_q;
  clf_cmd_t cmd;
  clf_sts_t sts;
  logic fire;
  logic [ValW-1:0] oval;
  logic [LenW-1:0] ocnt;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) target_q <= LenW'(1);
    else if (psel && penable && pwrite && paddr == RegTargetLen)
      target_q <= pwdata[LenW-1:0];
  end
  assign prdata = (paddr == RegTargetLen) ? {25'd0, target_q} : 32'd0;

  assign fire = s_axis_tvalid_i && s_axis_tready_o;

  clf_ctrl u_ctrl (.clk_i, .rst_ni, .in_fire_i(fire), .in_last_i(s_axis_tlast_i),
    .sts_i(sts), .cmd_o(cmd), .in_ready_o(s_axis_tready_o));

  clf_dp u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .in_value_i(s_axis_tdata_i),
    .target_i(target_q), .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o), .out_value_o(oval),
    .out_found_o(m_axis_tuser_o), .out_count_o(ocnt),
    .out_last_o(m_axis_tlast_o), .sts_o(sts));

  assign m_axis_tdata_o = {1'b0, ocnt, oval};
endmodule

@@ test/circular_lis_finder_test.sv @@
`timescale 1ns / 1ps
module circular_lis_finder_test;
  import clf_pkg::*;

  // One expected output word of a search.
  typedef struct {
    logic [31:0] seq_value;
    logic        found;
    logic [6:0]  result_count;
    logic        run_last;
  } lis_word_t;

  // Scoreboard: holds the loaded sequence and target, predicts the output words
  // of each search, and checks the words the block emits.
  class lis_scoreboard;
    logic [31:0] values[MaxItems];
    int          loaded;
    int          target;
    lis_word_t   pending[$];
    int          errors;

    function void reset_state();
      loaded = 0;
      target = 1;
      pending.delete();
      errors = 0;
    endfunction

    // Run the strictly-increasing LIS program over the rotation that starts at
    // rot. On success, return 1 and leave the chain in pred_q and its end in stop.
    function bit try_rotation(int rot, int n, output int stop, ref int pred_q[MaxItems]);
      int len_q[MaxItems];
      logic signed [31:0] vi;
      logic signed [31:0] vj;
      int cand;
      for (int i = 0; i < n; i++) begin
        len_q[i] = 1;
        pred_q[i] = 0;
      end
      stop = 0;
      for (int i = 1; i < n; i++) begin
        vi = values[(rot + i) % n];
        for (int j = 0; j < i; j++) begin
          vj = values[(rot + j) % n];
          if (vi > vj) begin
            cand = len_q[j] + 1;
            if (cand > len_q[i]) begin
              len_q[i] = cand;
              pred_q[i] = j;
            end
            if (cand == target) begin
              stop = i;
              return 1;
            end
          end
        end
      end
      return 0;
    endfunction

    // Note one accepted input word; on the last word, predict the search.
    function void note_word(logic [31:0] value, logic last);
      int n;
      int rot;
      int stop;
      int idx;
      int pred_q[MaxItems];
      lis_word_t w;
      lis_word_t run_q[$];
      bit hit;
      if (loaded < MaxItems) begin
        values[loaded] = value;
        loaded++;
      end
      if (!last) return;
      n = loaded;
      loaded = 0;
      hit = 0;
      rot = 0;
      for (int t = 1; t <= n; t++) begin
        rot = t % n;
        if (try_rotation(rot, n, stop, pred_q)) begin
          hit = 1;
          break;
        end
      end
      if (!hit) begin
        w.seq_value = '0;
        w.found = 1'b0;
        w.result_count = '0;
        w.run_last = 1'b1;
        pending.push_back(w);
        return;
      end
      // Walk the chain back from its end, then emit it ascending.
      idx = stop;
      for (int k = target; k > 0; k--) begin
        w.seq_value = values[(rot + idx) % n];
        w.found = 1'b1;
        w.result_count = 7'(target);
        w.run_last = (k == target);
        run_q.push_front(w);
        idx = pred_q[idx % MaxItems] % MaxItems;
      end
      foreach (run_q[i]) pending.push_back(run_q[i]);
    endfunction

    // Compare one emitted word with the oldest expected word.
    function void check_word(lis_word_t got);
      lis_word_t exp_w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: value %h found %b count %0d last %b",
                   got.seq_value, got.found, got.result_count, got.run_last);
        return;
      end
      exp_w = pending.pop_front();
      if (got.seq_value !== exp_w.seq_value || got.found !== exp_w.found ||
          got.result_count !== exp_w.result_count || got.run_last !== exp_w.run_last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp value %h found %b count %0d last %b, got %h %b %0d %b",
                   exp_w.seq_value, exp_w.found, exp_w.result_count, exp_w.run_last,
                   got.seq_value, got.found, got.result_count, got.run_last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lis_scoreboard lis_sb;
  int  send_idle_pct;
  int  sink_stall_pct;

  circular_lis_finder i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Sink side: stall at random at each falling edge, sample at the rising edge.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    lis_word_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.seq_value = m_axis_tdata_o[31:0];
      got.result_count = m_axis_tdata_o[38:32];
      got.found = m_axis_tuser_o;
      got.run_last = m_axis_tlast_o;
      lis_sb.check_word(got);
    end
  end

  // Write a register: setup cycle, then access cycle; the write lands at the
  // rising edge that ends the access cycle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= idx;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegTargetLen) lis_sb.target = data & 32'h7f;
  endtask

  // Send one word, called at a falling edge; hold it until the block takes it,
  // with random gaps first. Returns at the next falling edge with tvalid still
  // high, so the next word can follow with no gap.
  task automatic send_word(logic [31:0] value, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= value;
    s_axis_tlast_i <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    lis_sb.note_word(value, last);
    @(negedge clk_i);
  endtask

  // Send a whole sequence of n words, tlast on the final one.
  task automatic send_run(int n, int kind);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: v = $urandom;
        1: v = 32'($signed($urandom_range(20)) - 10);
        2: v = 32'(i * 3 - 40);
        default: v = 32'(100 - i);
      endcase
      send_word(v, i == n - 1);
    end
  endtask

  // Drain: drop tvalid, wait until every expected word has come, then settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (lis_sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int n;
    lis_sb = new();
    lis_sb.reset_state();
    send_idle_pct = 0;
    sink_stall_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    m_axis_tready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset target of 1 never hits; then extremes of the value.
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b1);
    drain();
    write_reg(RegTargetLen, 2);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b1);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b1);
    send_word(32'h5, 1'b0);
    send_word(32'h5, 1'b1);
    drain();
    // Target above the element count: not found.
    write_reg(RegTargetLen, 4);
    send_run(3, 2);
    drain();
    write_reg(RegTargetLen, 0);
    send_run(2, 2);
    drain();
    write_reg(RegTargetLen, 3);
    send_run(4, 3);
    drain();

    // Random phases: each picks a target and the idling pattern.
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 59; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 59; end
        default: begin send_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      write_reg(RegTargetLen, $urandom_range(2, 6));
      for (int r = 0; r < 5; r++) begin
        n = $urandom_range(2, 7);
        send_run(n, $urandom_range(3));
      end
      drain();
    end

    // Full-size and overfull sequences, largest target among them.
    send_idle_pct = 0;
    sink_stall_pct = 0;
    write_reg(RegTargetLen, 64);
    send_run(64, 2);
    drain();
    write_reg(RegTargetLen, 20);
    send_run(70, 1);
    drain();
    write_reg(RegTargetLen, 127);
    send_run(5, 2);
    drain();

    if (lis_sb.errors == 0) begin
      $display("** circular_lis_finder: PASSED **");
    end else begin
      $display("** circular_lis_finder: FAILED **");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("** circular_lis_finder: FAILED **");
    $finish;
  end
endmodule

@@ circular_lis_finder.f @@
src/clf_pkg.sv
src/clf_ram.sv
src/clf_ctrl.sv
src/clf_dp.sv
src/circular_lis_finder.sv
test/circular_lis_finder_test.sv
